### design/assert_macros.svh
// assertion macros used by the top-level design file
// no dependencies; compiles to nothing when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define ASSERT_CLK(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");
// expression must never be true outside reset
`define ASSERT_NEVER(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");
`else
`define ASSERT_CLK(name, clk, rst_n, prop)
`define ASSERT_NEVER(name, clk, rst_n, expr)
`endif

`endif

### design/bdj_pkg.sv
// types, constants and helpers for the backoff delay generator
// no dependencies; used by the interfaces, the divider and the top level
package bdj_pkg;

    localparam int CFG_W         = 32;
    localparam int RETRY_W       = 16;
    localparam int RND_W         = 8;
    localparam int DLY_W         = 31;
    localparam int MAX_DOUBLINGS = 32;
    localparam int STEP_W        = $clog2(MAX_DOUBLINGS + 1);

    localparam int FAIL_BASE = 2500;
    localparam int FAIL_STEP = 4 * 5;
    localparam int MULT_MAX  = 1000;
    localparam int MULT_W    = $clog2(MULT_MAX + 1);
    localparam int PER_W     = $clog2(FAIL_BASE + FAIL_STEP * 255 + 1);
    localparam int FAIL_W    = PER_W + MULT_W;
    localparam int FAIL_MAX  = (FAIL_BASE + FAIL_STEP * 255) * MULT_MAX;

    localparam int JIT_DIV   = 255;
    localparam int JIT_W     = DLY_W + RND_W;
    localparam int DIV_W     = JIT_W;
    localparam int FOLD_W    = $clog2(JIT_DIV + 1);

    localparam logic signed [CFG_W-1:0] MIN_RESET = 32'sd1000;
    localparam logic signed [CFG_W-1:0] MAX_RESET = 32'sd2000;
    localparam logic signed [CFG_W-1:0] CAP_RESET = 32'sd60000;

    typedef enum logic [1:0] {
        REG_MIN = 2'd0,
        REG_MAX = 2'd1,
        REG_CAP = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FAIL,
        ST_DOUBLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DLY_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic [DLY_W-1:0] sat_double(input logic [DLY_W-1:0] val,
                                                    input logic [DLY_W-1:0] cap);
        logic [DLY_W:0] twice;
        twice = {val, 1'b0};
        return (twice < {1'b0, cap}) ? twice[DLY_W-1:0] : cap;
    endfunction

endpackage

### design/bdj_in_if.sv
// request channel: retry number and random byte with valid/ready
// depends on bdj_pkg
interface bdj_in_if
    import bdj_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [RETRY_W-1:0] retry_number;
    logic        [RND_W-1:0]   random_byte;

    modport source (output valid, output retry_number, output random_byte, input ready);
    modport sink   (input valid, input retry_number, input random_byte, output ready);
endinterface

### design/bdj_out_if.sv
// response channel: delay and failover flag with valid/ready
// depends on bdj_pkg
interface bdj_out_if
    import bdj_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [DLY_W-1:0] delay_ms;
    logic             used_failover;

    modport source (output valid, output delay_ms, output used_failover, input ready);
    modport sink   (input valid, input delay_ms, input used_failover, output ready);
endinterface

### design/bdj_div255.sv
// divider by 255: folds the upper bytes onto the low byte, one shift and add per cycle
// depends on bdj_pkg
module bdj_div255
    import bdj_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W-1:0] num_reg, num_next;
    logic [DLY_W-1:0] quo_reg, quo_next;

    logic [DIV_W-1:0] high_part;
    logic             folded;

    // x = 256a + b gives x / 255 = a + (a + b) / 255
    assign high_part = num_reg >> FOLD_W;
    assign folded    = (high_part == '0);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        num_next  = num_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            num_next  = req.dividend;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            if (folded)
            begin
                quo_next  = quo_reg + DLY_W'(num_reg[FOLD_W-1:0] == FOLD_W'(JIT_DIV));
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                quo_next = quo_reg + high_part[DLY_W-1:0];
                num_next = high_part + DIV_W'(num_reg[FOLD_W-1:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

### design/backoff_delay_with_jitter_top.sv
// channel   dir  payload                          handshake
// request   in   retry_number[16] random_byte[8]  valid/ready
// response  out  delay_ms[31] used_failover[1]    valid/ready
// config    in   cfg_index[2] cfg_data[32]        cfg_wr_en, no back-pressure
// failover items: output register loaded in ST_DONE, after ST_FAIL
// normal items: output register loaded in ST_DONE, after ST_DOUBLE with d doubling
// steps (at most min(retry_number, 32)), ST_MUL and ST_DIV with f folds (at most 6)
// request.ready is high only between items; a new item is taken while a result waits
// a full output register holds the finished item in ST_DONE until response.ready
// reset: async active low, config registers return to 1000 / 2000 / 60000, no clearing pass
// depends on bdj_pkg, bdj_in_if, bdj_out_if, bdj_div255, assert_macros.svh
`include "assert_macros.svh"

module backoff_delay_with_jitter_top
    import bdj_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    bdj_in_if.sink            request,
    bdj_out_if.source         response,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    logic signed [CFG_W-1:0] min_reg, max_reg, cap_reg;

    state_t              state_reg, state_next;
    logic [DLY_W-1:0]    lo_reg, lo_next;
    logic [DLY_W-1:0]    hi_reg, hi_next;
    logic [STEP_W-1:0]   steps_reg, steps_next;
    logic [MULT_W-1:0]   mult_reg, mult_next;
    logic [RND_W-1:0]    rnd_reg, rnd_next;
    logic                fail_reg, fail_next;
    logic [DLY_W-1:0]    res_reg, res_next;

    logic                out_valid_reg, out_valid_next;
    logic [DLY_W-1:0]    delay_reg;
    logic                used_fail_reg;

    logic                accept;
    logic                load;
    logic                bad_cfg;
    logic                fail_in;
    logic [STEP_W-1:0]   steps_in;
    logic [MULT_W-1:0]   mult_in;
    logic [DLY_W-1:0]    lo_in, hi_in, cap31;
    logic [PER_W-1:0]    per_try;
    logic [FAIL_W-1:0]   fail_prod;
    logic [JIT_W-1:0]    jit_prod;
    div_req_t            div_req;
    div_rsp_t            div_rsp;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= MIN_RESET;
            max_reg <= MAX_RESET;
            cap_reg <= CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_MIN: min_reg <= cfg_data;
                REG_MAX: max_reg <= cfg_data;
                REG_CAP: cap_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign accept  = request.valid && request.ready;
    assign bad_cfg = min_reg[CFG_W-1] || max_reg[CFG_W-1] || cap_reg[CFG_W-1]
                     || (max_reg < min_reg);
    assign fail_in = request.retry_number[RETRY_W-1] || bad_cfg;
    assign cap31   = cap_reg[DLY_W-1:0];
    assign lo_in   = (min_reg < cap_reg) ? min_reg[DLY_W-1:0] : cap31;
    assign hi_in   = (max_reg < cap_reg) ? max_reg[DLY_W-1:0] : cap31;

    always_comb
    begin
        if (request.retry_number >= signed'(RETRY_W'(MAX_DOUBLINGS)))
        begin
            steps_in = STEP_W'(MAX_DOUBLINGS);
        end
        else
        begin
            steps_in = request.retry_number[STEP_W-1:0];
        end

        if (request.retry_number[RETRY_W-1])
        begin
            mult_in = MULT_W'(1);
        end
        else if (request.retry_number >= signed'(RETRY_W'(MULT_MAX - 1)))
        begin
            mult_in = MULT_W'(MULT_MAX);
        end
        else
        begin
            mult_in = request.retry_number[MULT_W-1:0] + 1'b1;
        end
    end

    assign per_try   = PER_W'(FAIL_BASE) + PER_W'(rnd_reg) * PER_W'(FAIL_STEP);
    assign fail_prod = FAIL_W'(per_try) * FAIL_W'(mult_reg);
    assign jit_prod  = JIT_W'(hi_reg - lo_reg) * JIT_W'(rnd_reg);

    assign load = (state_reg == ST_DONE) && (!out_valid_reg || response.ready);

    always_comb
    begin
        state_next       = state_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        steps_next       = steps_reg;
        mult_next        = mult_reg;
        rnd_next         = rnd_reg;
        fail_next        = fail_reg;
        res_next         = res_reg;
        div_req.start    = 1'b0;
        div_req.dividend = DIV_W'(jit_prod);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    lo_next    = lo_in;
                    hi_next    = hi_in;
                    steps_next = steps_in;
                    mult_next  = mult_in;
                    rnd_next   = request.random_byte;
                    fail_next  = fail_in;
                    state_next = fail_in ? ST_FAIL : ST_DOUBLE;
                end
            end
            ST_FAIL:
            begin
                res_next   = DLY_W'(fail_prod);
                state_next = ST_DONE;
            end
            ST_DOUBLE:
            begin
                if ((steps_reg == '0) || (lo_reg >= cap31))
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    lo_next    = sat_double(lo_reg, cap31);
                    hi_next    = sat_double(hi_reg, cap31);
                    steps_next = steps_reg - 1'b1;
                end
            end
            ST_MUL:
            begin
                div_req.start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    res_next   = lo_reg + div_rsp.quotient;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (response.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        steps_reg <= steps_next;
        mult_reg  <= mult_next;
        rnd_reg   <= rnd_next;
        fail_reg  <= fail_next;
        res_reg   <= res_next;
        if (load)
        begin
            delay_reg     <= res_reg;
            used_fail_reg <= fail_reg;
        end
    end

    bdj_div255 u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign request.ready          = (state_reg == ST_IDLE);
    assign response.valid         = out_valid_reg;
    assign response.delay_ms      = delay_reg;
    assign response.used_failover = used_fail_reg;

    `ASSERT_CLK(a_fail_range, clk, rst_n, response.valid && response.used_failover |-> response.delay_ms <= DLY_W'(FAIL_MAX))
    `ASSERT_CLK(a_norm_cap, clk, rst_n, response.valid && !response.used_failover |-> response.delay_ms <= cap31)
    `ASSERT_CLK(a_lo_le_hi, clk, rst_n, state_reg == ST_DOUBLE |-> lo_reg <= hi_reg)
    `ASSERT_NEVER(a_div_stray, clk, rst_n, div_rsp.done && state_reg != ST_DIV)

endmodule
